// File: rtl/core/rrcs_pkg.sv
package rrcs_pkg;

  // Function codes carried in the input tuser field.
  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_READ    = 2'd2
  } func_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_TICK_RELOAD  = 3'd0,
    CFG_RAMP_LOW     = 3'd1,
    CFG_RAMP_STEP    = 3'd2,
    CFG_BAND_LOW     = 3'd3,
    CFG_BAND_HIGH    = 3'd4,
    CFG_MIN_OUTLIERS = 3'd5
  } cfg_idx_e;

  localparam int unsigned SampleW  = 12;
  localparam int unsigned CountW   = 9;
  localparam int unsigned CfgDataW = 12;

  localparam logic [SampleW-1:0] DacMax       = 12'd4095;
  localparam logic [CountW-1:0]  OutlierMax   = 9'd511;

  localparam logic [7:0]         TickReloadRst  = 8'd10;
  localparam logic [11:0]        RampLowRst     = 12'd50;
  localparam logic [3:0]         RampStepRst    = 4'd8;
  localparam logic [11:0]        BandLowRst     = 12'd2390;
  localparam logic [11:0]        BandHighRst    = 12'd2480;
  localparam logic [CountW-1:0]  MinOutliersRst = 9'd10;

  // One result word; first member sits in the highest bits, so the list
  // below runs from the top of tdata down to bit 0.
  typedef struct packed {
    logic [1:0]         pad;
    logic               frame_pending;
    logic [SampleW-1:0] read_data;
    logic [CountW-1:0]  outlier_total;
    logic               frame_valid;
    logic               ready_half;
    logic               frame_ready;
    logic [SampleW-1:0] dac_value;
    logic               dac_update;
  } result_t;

endpackage

// File: rtl/core/radar_ramp_capture_sequencer_top.sv
// FMCW ramp capture sequencer with a ping-pong sample store. Each input word
// is a timer tick (with the ADC sample present at that tick), a frame release
// or a read of the ready frame, and each one yields exactly one result word.
// Ticks are prescaled by tick_reload; a taken sample is written into the half
// being filled while the DAC ramp value (FRAME_SAMPLES - position) * ramp_step
// + ramp_low, saturated at 4095, is reported. When a half is full, the next
// taken sample swaps halves and hands the full half over as the ready frame,
// unless the previous frame is still unreleased, in which case that tick is
// dropped. Each frame counts samples outside [band_low, band_high] and is
// marked valid when that count reaches min_outliers. The block takes one word
// per clock cycle while the result output is not held back. An accepted word
// updates the sequencer state and issues the registered store read into stage
// one; the output register then loads the result word. The store holds
// 2 * FRAME_SAMPLES entries of 12 bits with one write and one read port, and
// needs no clearing pass after reset, since a half becomes readable only once
// it has been filled. The configuration port is always ready; write it only
// while no words are in flight.
module radar_ramp_capture_sequencer_top #(
  parameter int unsigned FRAME_SAMPLES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [11:0] adc_sample, [19:12] read_index, [23:20] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] func
  // Result words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [0] dac_update, [12:1] dac_value, [13] frame_ready,
                                     // [14] ready_half, [15] frame_valid,
                                     // [24:16] outlier_total, [36:25] read_data,
                                     // [37] frame_pending, [39:38] zero
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  // Position counter holds 0..FRAME_SAMPLES; the store spans both halves.
  localparam int unsigned PosW  = $clog2(FRAME_SAMPLES + 1);
  localparam int unsigned AddrW = $clog2(2 * FRAME_SAMPLES);
  localparam int unsigned ProdW = PosW + 4;
  localparam int unsigned SumW  = (ProdW + 1 > 13) ? ProdW + 1 : 13;
  localparam int unsigned IdxW  = PosW + 8;

  localparam logic [PosW-1:0]  FramePos  = PosW'(FRAME_SAMPLES);
  localparam logic [AddrW-1:0] HalfBase  = AddrW'(FRAME_SAMPLES);
  localparam logic [IdxW-1:0]  FrameIdx  = IdxW'(FRAME_SAMPLES);

  // Configuration registers.
  logic [7:0]                   tick_reload_q;
  logic [11:0]                  ramp_low_q;
  logic [3:0]                   ramp_step_q;
  logic [11:0]                  band_low_q;
  logic [11:0]                  band_high_q;
  logic [rrcs_pkg::CountW-1:0]  min_outliers_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_reload_q  <= rrcs_pkg::TickReloadRst;
      ramp_low_q     <= rrcs_pkg::RampLowRst;
      ramp_step_q    <= rrcs_pkg::RampStepRst;
      band_low_q     <= rrcs_pkg::BandLowRst;
      band_high_q    <= rrcs_pkg::BandHighRst;
      min_outliers_q <= rrcs_pkg::MinOutliersRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (rrcs_pkg::cfg_idx_e'(cfg_index_i))
        rrcs_pkg::CFG_TICK_RELOAD:  tick_reload_q  <= cfg_data_i[7:0];
        rrcs_pkg::CFG_RAMP_LOW:     ramp_low_q     <= cfg_data_i;
        rrcs_pkg::CFG_RAMP_STEP:    ramp_step_q    <= cfg_data_i[3:0];
        rrcs_pkg::CFG_BAND_LOW:     band_low_q     <= cfg_data_i;
        rrcs_pkg::CFG_BAND_HIGH:    band_high_q    <= cfg_data_i;
        rrcs_pkg::CFG_MIN_OUTLIERS: min_outliers_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Input word fields.
  logic [1:0]  func;
  logic [11:0] adc_sample;
  logic [7:0]  read_index;

  assign func       = s_axis_tuser;
  assign adc_sample = s_axis_tdata[11:0];
  assign read_index = s_axis_tdata[19:12];

  // Sequencer state.
  logic [PosW-1:0]             wpos_q, wpos_d;
  logic                        fill_half_q, fill_half_d;
  logic                        pending_q, pending_d;
  logic                        ready_half_q, ready_half_d;
  logic [7:0]                  countdown_q, countdown_d;
  logic [rrcs_pkg::CountW-1:0] run_out_q, run_out_d;
  logic [rrcs_pkg::CountW-1:0] frame_out_q, frame_out_d;

  // Pipeline: stage one holds the result without read data, the output
  // register holds the finished word.
  logic                 s1_valid_q;
  rrcs_pkg::result_t    s1_res_q, s1_res_d;
  logic                 s1_rdsel_q, rdsel_d;
  logic                 out_valid_q;
  rrcs_pkg::result_t    out_res_q, out_res_d;
  logic                 in_acc, s1_move;

  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Store ports.
  logic [11:0]         store_q [2*FRAME_SAMPLES];
  logic [11:0]         rd_data_q;
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr, rd_addr;

  // Ramp and band arithmetic for the position a taken sample lands at.
  logic [PosW-1:0]  take_pos;
  logic [PosW-1:0]  remain;
  logic [ProdW-1:0] ramp_prod;
  logic [SumW-1:0]  ramp_sum;
  logic [11:0]      ramp_sat;
  logic             outlier;
  logic             idx_ok;

  always_comb begin
    wpos_d       = wpos_q;
    fill_half_d  = fill_half_q;
    pending_d    = pending_q;
    ready_half_d = ready_half_q;
    countdown_d  = countdown_q;
    run_out_d    = run_out_q;
    frame_out_d  = frame_out_q;
    wr_en        = 1'b0;
    s1_res_d     = '0;
    rdsel_d      = 1'b0;

    // A full half restarts at position zero after the swap.
    take_pos  = (wpos_q >= FramePos) ? '0 : wpos_q;
    remain    = FramePos - take_pos;
    ramp_prod = {4'b0000, remain} * {{PosW{1'b0}}, ramp_step_q};
    ramp_sum  = SumW'(ramp_prod) + SumW'(ramp_low_q);
    ramp_sat  = (ramp_sum > SumW'(rrcs_pkg::DacMax)) ? rrcs_pkg::DacMax : ramp_sum[11:0];
    outlier   = (adc_sample < band_low_q) || (adc_sample > band_high_q);
    idx_ok    = {{PosW{1'b0}}, read_index} < FrameIdx;

    case (rrcs_pkg::func_e'(func))
      rrcs_pkg::FUNC_TICK: begin
        if (countdown_q == 8'd0) begin
          countdown_d = tick_reload_q;
          // A full half with a frame still pending drops the tick.
          if (!(wpos_q >= FramePos && pending_q)) begin
            if (wpos_q >= FramePos) begin
              pending_d            = 1'b1;
              ready_half_d         = fill_half_q;
              fill_half_d          = !fill_half_q;
              frame_out_d          = run_out_q;
              s1_res_d.frame_ready = 1'b1;
            end
            wr_en               = 1'b1;
            wpos_d              = take_pos + PosW'(1);
            s1_res_d.dac_update = 1'b1;
            s1_res_d.dac_value  = ramp_sat;
            if (wpos_q >= FramePos) begin
              run_out_d = outlier ? rrcs_pkg::CountW'(1) : '0;
            end else if (outlier && run_out_q != rrcs_pkg::OutlierMax) begin
              run_out_d = run_out_q + rrcs_pkg::CountW'(1);
            end
          end
        end else begin
          countdown_d = countdown_q - 8'd1;
        end
      end
      rrcs_pkg::FUNC_RELEASE: begin
        pending_d = 1'b0;
      end
      rrcs_pkg::FUNC_READ: begin
        rdsel_d = pending_q && idx_ok;
      end
      default: ;
    endcase

    // Status always reflects the state after this word.
    s1_res_d.frame_pending = pending_d;
    if (pending_d) begin
      s1_res_d.ready_half    = ready_half_d;
      s1_res_d.outlier_total = frame_out_d;
      s1_res_d.frame_valid   = frame_out_d >= min_outliers_q;
    end
  end

  assign wr_addr = fill_half_d ? HalfBase + AddrW'(take_pos) : AddrW'(take_pos);
  assign rd_addr = ready_half_q ? HalfBase + AddrW'(read_index) : AddrW'(read_index);

  always_ff @(posedge clk_i) begin
    if (in_acc && wr_en) begin
      store_q[wr_addr] <= adc_sample;
    end
    if (in_acc) begin
      rd_data_q <= store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q       <= '0;
      fill_half_q  <= 1'b0;
      pending_q    <= 1'b0;
      ready_half_q <= 1'b0;
      countdown_q  <= '0;
      run_out_q    <= '0;
      frame_out_q  <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        wpos_q       <= wpos_d;
        fill_half_q  <= fill_half_d;
        pending_q    <= pending_d;
        ready_half_q <= ready_half_d;
        countdown_q  <= countdown_d;
        run_out_q    <= run_out_d;
        frame_out_q  <= frame_out_d;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The finished word merges the registered store read into stage one.
  always_comb begin
    out_res_d           = s1_res_q;
    out_res_d.read_data = s1_rdsel_q ? rd_data_q : '0;
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_res_q   <= s1_res_d;
      s1_rdsel_q <= rdsel_d;
    end
    if (s1_move) begin
      out_res_q <= out_res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q;

  // A handover always leaves a frame pending.
  a_ready_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.frame_ready) |-> out_res_q.frame_pending)
    else $error("frame handed over without a pending frame");

  // Only one half can be ready, and it is never the one being filled.
  a_half_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> (ready_half_q != fill_half_q))
    else $error("ready half equals fill half");

  // The write position never runs past a full half.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q <= FramePos)
    else $error("write position beyond frame");

  // Input stalls only when both pipeline stages are full and held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without backpressure");

  // A word without a DAC write reports a zero ramp value.
  a_dac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_res_q.dac_update) |-> (out_res_q.dac_value == '0))
    else $error("DAC value without DAC update");

endmodule
